[hdl/udpc_pkg.sv]
`default_nettype none

package udpc_pkg;

    localparam int unsigned MAX_PAYLOAD = 1472;
    localparam int unsigned HDR_BYTES   = 8;
    localparam int unsigned PLEN_W      = 11;
    localparam int unsigned PSEUDO_W    = 19;

    localparam logic [15:0] HDR_LEN   = 16'(HDR_BYTES);
    localparam logic [15:0] MAX_LEN   = 16'(MAX_PAYLOAD + HDR_BYTES);
    localparam logic [15:0] PROTO_UDP = 16'd17;

    typedef enum logic [1:0] {
        V_ACCEPTED      = 2'd0,
        V_SHORT         = 2'd1,
        V_BAD_LENGTH    = 2'd2,
        V_CSUM_MISMATCH = 2'd3
    } t_verdict;

    // Segment state as left by the byte that closed it.
    typedef struct packed {
        logic [15:0]         count;
        logic [15:0]         sport;
        logic [15:0]         dport;
        logic [15:0]         len;
        logic [15:0]         csum;
        logic [15:0]         sum;
        logic [7:0]          pend;
        logic [PSEUDO_W-1:0] pseudo;
    } t_seg_state;

endpackage

`default_nettype wire

[hdl/udpc_in_if.sv]
`default_nettype none

interface udpc_in_if import udpc_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        first_byte;
    logic        last_byte;
    logic [31:0] source_address;
    logic [31:0] destination_address;

    modport source (
        output valid, data_byte, first_byte, last_byte, source_address,
               destination_address,
        input  ready
    );
    modport sink (
        input  valid, data_byte, first_byte, last_byte, source_address,
               destination_address,
        output ready
    );
endinterface

`default_nettype wire

[hdl/udpc_out_if.sv]
`default_nettype none

interface udpc_out_if import udpc_pkg::*; ();
    logic              valid;
    logic              ready;
    t_verdict          verdict;
    logic [15:0]       source_port;
    logic [15:0]       destination_port;
    logic [PLEN_W-1:0] payload_length;
    logic              checksum_skipped;
    logic [31:0]       accepted_total;
    logic [31:0]       dropped_total;

    modport source (
        output valid, verdict, source_port, destination_port, payload_length,
               checksum_skipped, accepted_total, dropped_total,
        input  ready
    );
    modport sink (
        input  valid, verdict, source_port, destination_port, payload_length,
               checksum_skipped, accepted_total, dropped_total,
        output ready
    );
endinterface

`default_nettype wire

[hdl/udpc_parse.sv]
`default_nettype none

module udpc_parse import udpc_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_fire,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_first_byte,
    input  wire logic        i_last_byte,
    input  wire logic [31:0] i_source_address,
    input  wire logic [31:0] i_destination_address,
    output t_seg_state       o_seg
);

    logic [15:0]         r_pos, n_pos;
    logic [15:0]         r_count, n_count;
    logic [15:0]         r_sport, n_sport;
    logic [15:0]         r_dport, n_dport;
    logic [15:0]         r_len, n_len;
    logic [15:0]         r_csum, n_csum;
    logic [15:0]         r_sum, n_sum;
    logic [7:0]          r_pend, n_pend;
    logic [PSEUDO_W-1:0] r_pseudo, n_pseudo;

    logic        w_start;
    logic [15:0] w_pos;
    logic        w_hdr;
    logic        w_in_range;
    logic [15:0] w_base;
    logic [16:0] w_raw;

    always_comb begin
        w_start    = i_first_byte || (r_pos == '0);
        w_pos      = w_start ? '0 : r_pos;
        w_hdr      = (w_pos[15:3] == '0);
        w_in_range = w_hdr || (w_pos < r_len);
        w_base     = w_start ? '0 : r_sum;

        n_sport  = r_sport;
        n_dport  = r_dport;
        n_len    = r_len;
        n_csum   = r_csum;
        n_pend   = r_pend;
        n_sum    = w_base;
        n_pseudo = r_pseudo;

        if (w_hdr) begin
            case (w_pos[2:1])
                2'd0:    n_sport = {r_sport[7:0], i_data_byte};
                2'd1:    n_dport = {r_dport[7:0], i_data_byte};
                2'd2:    n_len   = {r_len[7:0], i_data_byte};
                default: n_csum  = {r_csum[7:0], i_data_byte};
            endcase
        end

        // Ones'-complement add of the completed 16-bit word, carry wrapped round.
        w_raw = {1'b0, w_base} + {1'b0, r_pend, i_data_byte};
        if (w_in_range) begin
            if (!w_pos[0]) begin
                n_pend = i_data_byte;
            end else begin
                n_sum = w_raw[15:0] + 16'(w_raw[16]);
            end
        end

        // The pseudo-header is summed once, when the addresses are sampled.
        if (w_start) begin
            n_pseudo = PSEUDO_W'(i_source_address[31:16])
                     + PSEUDO_W'(i_source_address[15:0])
                     + PSEUDO_W'(i_destination_address[31:16])
                     + PSEUDO_W'(i_destination_address[15:0])
                     + PSEUDO_W'(PROTO_UDP);
        end

        n_count = (w_pos == '1) ? w_pos : w_pos + 16'd1;
        n_pos   = i_last_byte ? '0 : n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_count  <= '0;
            r_sport  <= '0;
            r_dport  <= '0;
            r_len    <= '0;
            r_csum   <= '0;
            r_sum    <= '0;
            r_pend   <= '0;
            r_pseudo <= '0;
        end else if (i_fire) begin
            r_pos    <= n_pos;
            r_count  <= n_count;
            r_sport  <= n_sport;
            r_dport  <= n_dport;
            r_len    <= n_len;
            r_csum   <= n_csum;
            r_sum    <= n_sum;
            r_pend   <= n_pend;
            r_pseudo <= n_pseudo;
        end
    end

    assign o_seg.count  = r_count;
    assign o_seg.sport  = r_sport;
    assign o_seg.dport  = r_dport;
    assign o_seg.len    = r_len;
    assign o_seg.csum   = r_csum;
    assign o_seg.sum    = r_sum;
    assign o_seg.pend   = r_pend;
    assign o_seg.pseudo = r_pseudo;

endmodule

`default_nettype wire

[hdl/udpc_verdict.sv]
`default_nettype none

module udpc_verdict import udpc_pkg::*; (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_take,
    input  wire t_seg_state    i_seg,
    output t_verdict           o_verdict,
    output logic [15:0]        o_source_port,
    output logic [15:0]        o_destination_port,
    output logic [PLEN_W-1:0]  o_payload_length,
    output logic               o_checksum_skipped,
    output logic [31:0]        o_accepted_total,
    output logic [31:0]        o_dropped_total
);

    t_verdict          r_verdict, n_verdict;
    logic [15:0]       r_sport, n_sport;
    logic [15:0]       r_dport, n_dport;
    logic [PLEN_W-1:0] r_plen, n_plen;
    logic              r_skip, n_skip;
    logic [31:0]       r_acc, n_acc;
    logic [31:0]       r_drop, n_drop;

    logic        w_short;
    logic        w_bad_len;
    logic        w_ok;
    logic [15:0] w_pad;
    logic [19:0] w_total;
    logic [16:0] w_fold1;
    logic [15:0] w_fold2;
    logic        w_match;

    always_comb begin
        w_short   = (i_seg.count < HDR_LEN);
        w_bad_len = (i_seg.len < HDR_LEN) || (i_seg.len > i_seg.count)
                 || (i_seg.len > MAX_LEN);

        // An odd length leaves a high byte waiting; it is padded with zero.
        w_pad   = i_seg.len[0] ? {i_seg.pend, 8'h00} : '0;
        w_total = 20'(i_seg.sum) + 20'(w_pad) + 20'(i_seg.pseudo) + 20'(i_seg.len);
        // Folding twice gives the ones'-complement sum; the protocol term keeps
        // it away from zero, so all ones means the segment checks.
        w_fold1 = {1'b0, w_total[15:0]} + 17'(w_total[19:16]);
        w_fold2 = w_fold1[15:0] + 16'(w_fold1[16]);
        w_match = (w_fold2 == 16'hFFFF);

        n_sport = i_seg.sport;
        n_dport = i_seg.dport;
        n_skip  = 1'b0;
        w_ok    = 1'b0;
        if (w_short) begin
            n_verdict = V_SHORT;
            n_sport   = '0;
            n_dport   = '0;
        end else if (w_bad_len) begin
            n_verdict = V_BAD_LENGTH;
        end else if (i_seg.csum == '0) begin
            n_verdict = V_ACCEPTED;
            n_skip    = 1'b1;
            w_ok      = 1'b1;
        end else if (w_match) begin
            n_verdict = V_ACCEPTED;
            w_ok      = 1'b1;
        end else begin
            n_verdict = V_CSUM_MISMATCH;
        end

        n_plen = w_ok ? PLEN_W'(i_seg.len - HDR_LEN) : '0;
        n_acc  = w_ok ? r_acc + 32'd1 : r_acc;
        n_drop = w_ok ? r_drop : r_drop + 32'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_drop <= '0;
        end else if (i_take) begin
            r_acc  <= n_acc;
            r_drop <= n_drop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_verdict <= n_verdict;
            r_sport   <= n_sport;
            r_dport   <= n_dport;
            r_plen    <= n_plen;
            r_skip    <= n_skip;
        end
    end

    assign o_verdict          = r_verdict;
    assign o_source_port      = r_sport;
    assign o_destination_port = r_dport;
    assign o_payload_length   = r_plen;
    assign o_checksum_skipped = r_skip;
    assign o_accepted_total   = r_acc;
    assign o_dropped_total    = r_drop;

endmodule

`default_nettype wire

[hdl/udp_datagram_receive_check.sv]
`default_nettype none

// Channel   Dir   Words                       Handshake
// i_in      in    one segment byte + marks    valid/ready, taken when both high
// o_out     out   one verdict per last byte   valid/ready, taken when both high
//
// One byte is taken every cycle unless the pipeline stalls. A verdict is offered once its last
// byte has passed the input register, the segment state and the verdict register, in that order.
// Reset is synchronous and active low; it clears the segment state and both counters.
// Bytes keep flowing while a verdict waits; the pipeline stops only when a
// second finished segment meets an unread verdict.

module udp_datagram_receive_check import udpc_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    udpc_in_if.sink    i_in,
    udpc_out_if.source o_out
);

    logic        r_in_valid;
    logic [7:0]  r_data_byte;
    logic        r_first_byte;
    logic        r_last_byte;
    logic [31:0] r_source_address;
    logic [31:0] r_destination_address;
    logic        r_fin_valid;
    logic        r_out_valid;

    logic        w_out_take;
    logic        w_seg_go;
    logic        w_in_ready;
    logic        w_seg_fire;
    logic        w_out_fire;
    t_seg_state  w_seg;

    assign w_out_take = !r_out_valid || o_out.ready;
    assign w_seg_go   = !r_fin_valid || w_out_take;
    assign w_in_ready = !r_in_valid || w_seg_go;
    assign w_seg_fire = r_in_valid && w_seg_go;
    assign w_out_fire = r_fin_valid && w_out_take;

    assign i_in.ready  = w_in_ready;
    assign o_out.valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_fin_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_ready) begin
                r_in_valid <= i_in.valid;
            end
            if (w_seg_fire) begin
                r_fin_valid <= r_last_byte;
            end else if (w_out_fire) begin
                r_fin_valid <= 1'b0;
            end
            if (w_out_take) begin
                r_out_valid <= r_fin_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && w_in_ready) begin
            r_data_byte           <= i_in.data_byte;
            r_first_byte          <= i_in.first_byte;
            r_last_byte           <= i_in.last_byte;
            r_source_address      <= i_in.source_address;
            r_destination_address <= i_in.destination_address;
        end
    end

    udpc_parse u_parse (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_fire                (w_seg_fire),
        .i_data_byte           (r_data_byte),
        .i_first_byte          (r_first_byte),
        .i_last_byte           (r_last_byte),
        .i_source_address      (r_source_address),
        .i_destination_address (r_destination_address),
        .o_seg                 (w_seg)
    );

    udpc_verdict u_verdict (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_take             (w_out_fire),
        .i_seg              (w_seg),
        .o_verdict          (o_out.verdict),
        .o_source_port      (o_out.source_port),
        .o_destination_port (o_out.destination_port),
        .o_payload_length   (o_out.payload_length),
        .o_checksum_skipped (o_out.checksum_skipped),
        .o_accepted_total   (o_out.accepted_total),
        .o_dropped_total    (o_out.dropped_total)
    );

endmodule

`default_nettype wire

[test/testbench.sv]
`timescale 1ns / 100ps

module testbench;
    import udpc_pkg::*;

    typedef struct packed {
        logic [7:0]  data;
        logic        first;
        logic        last;
        logic [31:0] saddr;
        logic [31:0] daddr;
        int          tx_idle;
        int          rx_stall;
        logic        hold;
    } byte_item_t;

    typedef struct packed {
        t_verdict          verdict;
        logic [15:0]       sport;
        logic [15:0]       dport;
        logic [PLEN_W-1:0] plen;
        logic              skipped;
        logic [31:0]       accepted;
        logic [31:0]       dropped;
    } verdict_word_t;

    typedef enum int {
        SEG_GOOD,
        SEG_ZERO_CSUM,
        SEG_BAD_CSUM,
        SEG_LEN_LOW,
        SEG_LEN_OVER,
        SEG_TRAILING,
        SEG_SHORT,
        SEG_ABANDON
    } seg_kind_e;

    logic i_clk;
    logic i_rst_n;

    udpc_in_if  byte_if ();
    udpc_out_if verdict_if ();

    udp_datagram_receive_check u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (byte_if),
        .o_out   (verdict_if)
    );

    byte_item_t    byte_items[$];
    verdict_word_t verdict_q[$];
    byte_item_t    cur_item;
    int            rx_stall_pct;
    logic          in_taken;
    int            errors;

    int   gen_tx_idle;
    int   gen_rx_stall;
    logic gen_hold;
    int   gen_count;

    // Segment tracking state of the checker's own copy of the block.
    logic [15:0] seg_pos;
    logic [15:0] seg_sum;
    logic [7:0]  seg_pend;
    logic [15:0] hdr_sport;
    logic [15:0] hdr_dport;
    logic [15:0] hdr_len;
    logic [15:0] hdr_csum;
    logic [63:0] seg_addr;
    logic [31:0] accepted_cnt;
    logic [31:0] dropped_cnt;

    initial begin
        i_clk = 1'b0;
    end

    always #1 i_clk = ~i_clk;

    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] w);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, w};
        s = {1'b0, s[15:0]} + {16'h0000, s[16]};
        return s[15:0];
    endfunction

    task automatic track_segment_byte(input logic [7:0] b, input logic first, input logic last,
                                      input logic [31:0] sa, input logic [31:0] da);
        logic [31:0]   pos;
        logic [31:0]   cnt;
        logic [15:0]   s;
        logic          ok;
        verdict_word_t w;
        ok = 1'b0;
        if (first || seg_pos == 16'h0000) begin
            pos      = 0;
            seg_sum  = 16'h0000;
            seg_addr = {sa, da};
        end else begin
            pos = {16'h0000, seg_pos};
        end
        case (pos)
            0, 1: hdr_sport = {hdr_sport[7:0], b};
            2, 3: hdr_dport = {hdr_dport[7:0], b};
            4, 5: hdr_len   = {hdr_len[7:0], b};
            6, 7: hdr_csum  = {hdr_csum[7:0], b};
            default: ;
        endcase
        if (pos < HDR_BYTES || pos < {16'h0000, hdr_len}) begin
            if (!pos[0]) begin
                seg_pend = b;
            end else begin
                seg_sum = ones_add(seg_sum, {seg_pend, b});
            end
        end
        cnt = pos + 1;
        seg_pos = (cnt > 32'h0000_FFFF) ? 16'hFFFF : cnt[15:0];
        if (last) begin
            w.verdict = V_ACCEPTED;
            w.sport   = 16'h0000;
            w.dport   = 16'h0000;
            w.plen    = '0;
            w.skipped = 1'b0;
            if (cnt < HDR_BYTES) begin
                w.verdict = V_SHORT;
            end else begin
                w.sport = hdr_sport;
                w.dport = hdr_dport;
                if (hdr_len < HDR_LEN || {16'h0000, hdr_len} > cnt || hdr_len > MAX_LEN) begin
                    w.verdict = V_BAD_LENGTH;
                end else if (hdr_csum == 16'h0000) begin
                    w.verdict = V_ACCEPTED;
                    w.skipped = 1'b1;
                    ok = 1'b1;
                end else begin
                    s = seg_sum;
                    // An odd length leaves a half word that is padded with zero.
                    if (hdr_len[0]) begin
                        s = ones_add(s, {seg_pend, 8'h00});
                    end
                    s = ones_add(s, seg_addr[63:48]);
                    s = ones_add(s, seg_addr[47:32]);
                    s = ones_add(s, seg_addr[31:16]);
                    s = ones_add(s, seg_addr[15:0]);
                    s = ones_add(s, PROTO_UDP);
                    s = ones_add(s, hdr_len);
                    if (s == 16'hFFFF) begin
                        w.verdict = V_ACCEPTED;
                        ok = 1'b1;
                    end else begin
                        w.verdict = V_CSUM_MISMATCH;
                    end
                end
                if (ok) begin
                    w.plen = PLEN_W'(hdr_len - HDR_LEN);
                end
            end
            if (ok) begin
                accepted_cnt = accepted_cnt + 32'd1;
            end else begin
                dropped_cnt = dropped_cnt + 32'd1;
            end
            w.accepted = accepted_cnt;
            w.dropped  = dropped_cnt;
            verdict_q.push_back(w);
            seg_pos = 16'h0000;
        end
    endtask

    task automatic set_phase(input int tx, input int rx);
        gen_tx_idle  = tx;
        gen_rx_stall = rx;
        gen_hold     = 1'b1;
    endtask

    task automatic push_byte(input logic [7:0] b, input logic first, input logic last,
                             input logic [31:0] sa, input logic [31:0] da);
        byte_item_t e;
        e.data     = b;
        e.first    = first;
        e.last     = last;
        e.saddr    = sa;
        e.daddr    = da;
        e.tx_idle  = gen_tx_idle;
        e.rx_stall = gen_rx_stall;
        e.hold     = gen_hold;
        gen_hold   = 1'b0;
        gen_count  = gen_count + 1;
        byte_items.push_back(e);
    endtask

    task automatic send_datagram(input logic [31:0] sa, input logic [31:0] da,
                                 input logic [15:0] sp, input logic [15:0] dp,
                                 input int plen, input seg_kind_e kind,
                                 input logic mark_first, input int extra);
        logic [7:0]  seg[$];
        logic [15:0] ulen;
        logic [15:0] s;
        logic [15:0] csum;
        int          i;
        int          n;
        if (kind == SEG_LEN_OVER && plen == 0) begin
            plen = 1;
        end
        ulen = 16'(plen + HDR_BYTES);
        seg.push_back(sp[15:8]);
        seg.push_back(sp[7:0]);
        seg.push_back(dp[15:8]);
        seg.push_back(dp[7:0]);
        seg.push_back(ulen[15:8]);
        seg.push_back(ulen[7:0]);
        seg.push_back(8'h00);
        seg.push_back(8'h00);
        repeat (plen) seg.push_back(8'($urandom));
        s = 16'h0000;
        for (i = 0; i < seg.size(); i = i + 2) begin
            s = ones_add(s, {seg[i], (i + 1 < seg.size()) ? seg[i + 1] : 8'h00});
        end
        s = ones_add(s, sa[31:16]);
        s = ones_add(s, sa[15:0]);
        s = ones_add(s, da[31:16]);
        s = ones_add(s, da[15:0]);
        s = ones_add(s, PROTO_UDP);
        s = ones_add(s, ulen);
        csum = ~s;
        // A computed checksum of zero goes on the wire as all ones.
        if (csum == 16'h0000) begin
            csum = 16'hFFFF;
        end
        case (kind)
            SEG_ZERO_CSUM: csum = 16'h0000;
            SEG_LEN_LOW: begin
                seg[4] = 8'h00;
                seg[5] = 8'($urandom_range(7));
            end
            default: ;
        endcase
        seg[6] = csum[15:8];
        seg[7] = csum[7:0];
        n = -1;
        case (kind)
            SEG_BAD_CSUM: begin
                i = $urandom_range(seg.size() - 1);
                seg[i] = seg[i] ^ (8'h01 << $urandom_range(7));
            end
            SEG_LEN_OVER: n = $urandom_range(HDR_BYTES, seg.size() - 1);
            SEG_TRAILING: repeat (extra) seg.push_back(8'($urandom));
            SEG_SHORT:    n = $urandom_range(1, HDR_BYTES - 1);
            SEG_ABANDON:  n = $urandom_range(1, seg.size());
            default: ;
        endcase
        if (n >= 0) begin
            while (seg.size() > n) void'(seg.pop_back());
        end
        for (i = 0; i < seg.size(); i++) begin
            push_byte(seg[i], mark_first && i == 0,
                      kind != SEG_ABANDON && i == seg.size() - 1,
                      (i == 0) ? sa : $urandom, (i == 0) ? da : $urandom);
        end
    endtask

    // Driver: a new word is offered only once the previous one has been taken.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            byte_if.valid <= 1'b0;
        end else if (!byte_if.valid || in_taken) begin
            if (byte_items.size() != 0 && !(byte_items[0].hold && verdict_q.size() != 0)
                    && $urandom_range(99) >= byte_items[0].tx_idle) begin
                cur_item     = byte_items.pop_front();
                rx_stall_pct = cur_item.rx_stall;
                byte_if.valid               <= 1'b1;
                byte_if.data_byte           <= cur_item.data;
                byte_if.first_byte          <= cur_item.first;
                byte_if.last_byte           <= cur_item.last;
                byte_if.source_address      <= cur_item.saddr;
                byte_if.destination_address <= cur_item.daddr;
            end else begin
                byte_if.valid <= 1'b0;
            end
        end
        verdict_if.ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // Monitor: tracks every accepted byte and checks every accepted verdict.
    always @(posedge i_clk) begin
        verdict_word_t want;
        verdict_word_t got;
        in_taken <= byte_if.valid && byte_if.ready;
        if (i_rst_n && byte_if.valid && byte_if.ready) begin
            track_segment_byte(byte_if.data_byte, byte_if.first_byte, byte_if.last_byte,
                               byte_if.source_address, byte_if.destination_address);
        end
        if (i_rst_n && verdict_if.valid && verdict_if.ready) begin
            got.verdict  = verdict_if.verdict;
            got.sport    = verdict_if.source_port;
            got.dport    = verdict_if.destination_port;
            got.plen     = verdict_if.payload_length;
            got.skipped  = verdict_if.checksum_skipped;
            got.accepted = verdict_if.accepted_total;
            got.dropped  = verdict_if.dropped_total;
            if (verdict_q.size() == 0) begin
                $display("%0t: verdict word with none expected: verdict=%0d", $time,
                         got.verdict);
                errors = errors + 1;
            end else begin
                want = verdict_q.pop_front();
                if (got !== want) begin
                    $display("%0t: verdict mismatch expected v=%0d sp=%h dp=%h len=%0d skip=%0d acc=%0d drop=%0d",
                             $time, want.verdict, want.sport, want.dport, want.plen,
                             want.skipped, want.accepted, want.dropped);
                    $display("%0t:                  actual v=%0d sp=%h dp=%h len=%0d skip=%0d acc=%0d drop=%0d",
                             $time, got.verdict, got.sport, got.dport, got.plen,
                             got.skipped, got.accepted, got.dropped);
                    errors = errors + 1;
                end
            end
        end
    end

    initial begin
        int        pkt;
        int        start;
        int        r;
        int        plen;
        logic      after_abandon;
        logic      mark;
        seg_kind_e kind;
        i_rst_n  = 1'b0;
        in_taken = 1'b0;
        errors   = 0;
        byte_if.valid               = 1'b0;
        byte_if.data_byte           = 8'h00;
        byte_if.first_byte          = 1'b0;
        byte_if.last_byte           = 1'b0;
        byte_if.source_address      = 32'h0;
        byte_if.destination_address = 32'h0;
        verdict_if.ready            = 1'b0;
        rx_stall_pct = 0;
        gen_count    = 0;
        seg_pos      = 16'h0000;
        seg_sum      = 16'h0000;
        seg_pend     = 8'h00;
        hdr_sport    = 16'h0000;
        hdr_dport    = 16'h0000;
        hdr_len      = 16'h0000;
        hdr_csum     = 16'h0000;
        seg_addr     = 64'h0;
        accepted_cnt = 32'h0;
        dropped_cnt  = 32'h0;

        // Directed: a one-byte segment, a bare header with no checksum, an odd
        // length with a real checksum, and a length field below the header.
        set_phase(0, 0);
        push_byte(8'hFF, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'h0);
        send_datagram(32'hFFFF_FFFF, 32'h0, 16'hFFFF, 16'h0000, 0, SEG_ZERO_CSUM, 1'b1, 0);
        send_datagram(32'h0, 32'hFFFF_FFFF, 16'h0000, 16'hFFFF, 1, SEG_GOOD, 1'b1, 0);
        send_datagram($urandom, $urandom, 16'($urandom), 16'($urandom), 0, SEG_LEN_LOW,
                      1'b1, 0);

        start = gen_count;
        after_abandon = 1'b0;
        for (pkt = 0; (gen_count - start) < 600 || pkt < 48; pkt++) begin
            if (pkt % 12 == 0) begin
                case ((pkt / 12) % 4)
                    0: set_phase(0, 0);
                    1: set_phase(70, 0);
                    2: set_phase(0, 70);
                    default: set_phase(36, 36);
                endcase
            end
            r = $urandom_range(99);
            if (r >= 95) begin
                repeat ($urandom_range(1, 4)) begin
                    push_byte(8'($urandom), 1'($urandom_range(1)), 1'($urandom_range(1)),
                              $urandom, $urandom);
                end
            end else begin
                if (r < 40)      kind = SEG_GOOD;
                else if (r < 50) kind = SEG_ZERO_CSUM;
                else if (r < 62) kind = SEG_BAD_CSUM;
                else if (r < 70) kind = SEG_LEN_LOW;
                else if (r < 78) kind = SEG_LEN_OVER;
                else if (r < 86) kind = SEG_TRAILING;
                else if (r < 90) kind = SEG_SHORT;
                else             kind = SEG_ABANDON;
                plen = ($urandom_range(49) == 0) ? $urandom_range(25, 300)
                                                 : $urandom_range(0, 24);
                mark = after_abandon || ($urandom_range(99) >= 15);
                send_datagram($urandom, $urandom, 16'($urandom), 16'($urandom), plen, kind,
                              mark, $urandom_range(1, 6));
                after_abandon = (kind == SEG_ABANDON);
            end
        end

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        do begin
            @(posedge i_clk);
            #0.2;
        end while (byte_items.size() != 0 || byte_if.valid || verdict_q.size() != 0);
        repeat (8) @(posedge i_clk);

        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

[files.f]
hdl/udpc_pkg.sv
hdl/udpc_in_if.sv
hdl/udpc_out_if.sv
hdl/udpc_parse.sv
hdl/udpc_verdict.sv
hdl/udp_datagram_receive_check.sv
test/testbench.sv
